// ----- hw/rtl/binary_lifting_ancestor_engine_macros.svh -----
// Assertion macros for the ancestor engine.
`ifndef BINARY_LIFTING_ANCESTOR_ENGINE_MACROS_SVH
`define BINARY_LIFTING_ANCESTOR_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define BLAE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BLAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BLAE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BLAE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/blae_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package blae_pkg;

	typedef logic signed [11:0] node_t;

	localparam node_t NODE_NONE = -12'sd1;

	// item modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_BUILD = 2'd1;
	localparam logic [1:0] MODE_LCA   = 2'd2;
	localparam logic [1:0] MODE_KTH   = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [10:0]        node_a;
		logic signed [11:0] node_b;
		logic [9:0]         depth_in;
		logic [9:0]         steps;
	} item_t;

	typedef struct packed {
		node_t       answer_node;
		logic [10:0] distance;
		logic        status;
	} result_t;

	typedef struct packed {
		logic par_we;
		logic dep_we;
		logic jmp_we;
	} tbl_wr_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LCA_DA,
		ST_LCA_DB,
		ST_CLIMB,
		ST_CLIMB_WAIT,
		ST_CLIMB_END,
		ST_LCA_JP,
		ST_LCA_JQ,
		ST_LCA_CMP,
		ST_LCA_PAR,
		ST_LCA_PARW,
		ST_LCA_DIST,
		ST_LCA_DISTW,
		ST_B0_RD,
		ST_B0_WR,
		ST_BJ_RD,
		ST_BJ_MID,
		ST_BJ_WR,
		ST_DONE
	} state_t;

	// node number lies in 1..act
	function automatic logic is_node(input node_t v, input logic [10:0] act);
		return !v[11] && (v != 12'sd0) && (v[10:0] <= act);
	endfunction

	function automatic node_t norm_node(input node_t v, input logic [10:0] act);
		return is_node(v, act) ? v : NODE_NONE;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/blae_tables.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Parent, depth and jump tables. One write and one registered read per table per cycle.
module blae_tables import blae_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LOG_LEVELS = 11,
	localparam int NW = $clog2(MAX_NODES),
	localparam int JD = MAX_NODES * LOG_LEVELS,
	localparam int JAW = $clog2(JD)
) (
	input  wire logic           clk,
	input  wire tbl_wr_t        wr,
	input  wire logic [NW-1:0]  node_waddr,
	input  wire node_t          par_wdata,
	input  wire logic [9:0]     dep_wdata,
	input  wire logic [NW-1:0]  par_raddr,
	input  wire logic [NW-1:0]  dep_raddr,
	output node_t               par_rdata,
	output logic [9:0]          dep_rdata,
	input  wire logic [JAW-1:0] jmp_waddr,
	input  wire node_t          jmp_wdata,
	input  wire logic [JAW-1:0] jmp_raddr,
	output node_t               jmp_rdata
);

	node_t      par_mem [MAX_NODES];
	logic [9:0] dep_mem [MAX_NODES];
	node_t      jmp_mem [JD];

	always_ff @(posedge clk) begin
		if (wr.par_we) begin
			par_mem[node_waddr] <= par_wdata;
		end
		par_rdata <= par_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.dep_we) begin
			dep_mem[node_waddr] <= dep_wdata;
		end
		dep_rdata <= dep_mem[dep_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.jmp_we) begin
			jmp_mem[jmp_waddr] <= jmp_wdata;
		end
		jmp_rdata <= jmp_mem[jmp_raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/binary_lifting_ancestor_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Tree ancestor engine by binary lifting.
// Items come in on item/item_valid/item_stall and one result per item leaves on
// result/result_valid/result_stall; a transfer happens when valid is high and stall low.
// node_count is written on cfg_data/cfg_valid/cfg_ready, only while the engine is idle.
// Use: load every node (mode load), send one build item, then send queries.
// One item is in work at a time; item_stall is high from transfer until the engine
// has handed its result to the output register and returned to idle.
// Per item: a load writes the parent and depth tables; a k-th ancestor climbs
// by jump-table reads from the top level down; a common ancestor reads both
// depths, climbs to equal depth, walks the LOG_LEVELS levels from the top, then
// reads the parent and depth tables; a build fills level zero from the parents,
// then every further level from the one below it.
// The output register holds one finished result; while result_stall is high it
// holds, and the engine takes the next item but parks it once done.
// Reset clears the control state and sets node_count to 1. The tables are not
// cleared: a node that was never loaded, or a query before a build, answers junk.
`include "binary_lifting_ancestor_engine_macros.svh"

module binary_lifting_ancestor_engine import blae_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LOG_LEVELS = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int JAW = $clog2(MAX_NODES * LOG_LEVELS);
	localparam int LW = $clog2(LOG_LEVELS);
	localparam int CAP = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
	localparam logic [LW-1:0] LVL_TOP = LW'(LOG_LEVELS - 1);

	// table index of a node number (1-based)
	function automatic logic [NW-1:0] nidx(input node_t v);
		return NW'(v - 12'sd1);
	endfunction

	// jump entry (v, l) lives at l * MAX_NODES + v - 1
	function automatic logic [JAW-1:0] jaddr(input node_t v, input logic [LW-1:0] l);
		return JAW'(l) * JAW'(MAX_NODES) + JAW'(nidx(v));
	endfunction

	state_t state_q, state_d;

	logic [10:0]   node_count_q;
	logic [10:0]   active;

	// item fields
	logic [1:0]    mode_q;
	logic [10:0]   a_q;
	node_t         b_q;
	logic [9:0]    dep_q;

	// walk state
	node_t         p_q, q_q, jp_q;
	logic [9:0]    k_q;
	logic [9:0]    da_q, db_q;
	logic [LW-1:0] lvl_q;
	logic [10:0]   v_q;

	// answer under construction
	node_t         ans_q;
	logic [10:0]   dist_q;
	logic          status_q;

	logic          result_valid_q;
	result_t       result_q;

	node_t         a_node, v_node, par_norm, jmp_norm, jq;
	logic          a_ok, b_ok, load_ok, take, last_v, out_free;
	logic [9:0]    span;
	logic [11:0]   dsum, dtwice;

	tbl_wr_t          tbl_wr;
	logic [NW-1:0]    node_waddr, par_raddr, dep_raddr;
	logic [JAW-1:0]   jmp_waddr, jmp_raddr;
	node_t            jmp_wdata, par_rdata, jmp_rdata;
	logic [9:0]       dep_rdata;

	blae_tables #(
		.MAX_NODES (MAX_NODES),
		.LOG_LEVELS(LOG_LEVELS)
	) u_tables (
		.clk       (clk),
		.wr        (tbl_wr),
		.node_waddr(node_waddr),
		.par_wdata (b_q),
		.dep_wdata (dep_q),
		.par_raddr (par_raddr),
		.dep_raddr (dep_raddr),
		.par_rdata (par_rdata),
		.dep_rdata (dep_rdata),
		.jmp_waddr (jmp_waddr),
		.jmp_wdata (jmp_wdata),
		.jmp_raddr (jmp_raddr),
		.jmp_rdata (jmp_rdata)
	);

	// node_count above the table size acts as the table size
	assign active   = (node_count_q > 11'(CAP)) ? 11'(CAP) : node_count_q;
	assign a_node   = {1'b0, a_q};
	assign v_node   = {1'b0, v_q};
	assign a_ok     = is_node(a_node, active);
	assign b_ok     = is_node(b_q, active);
	assign load_ok  = a_ok && ((b_q == NODE_NONE) || b_ok);
	assign par_norm = norm_node(par_rdata, active);
	assign jmp_norm = norm_node(jmp_rdata, active);
	assign jq       = (q_q == NODE_NONE) ? NODE_NONE : jmp_norm;
	// climb step at this level still fits in the remaining count
	assign take     = (k_q >> lvl_q) != 10'd0;
	assign span     = 10'd1 << lvl_q;
	assign last_v   = (v_q == active);
	assign out_free = !result_valid_q || !result_stall;
	assign dsum     = {2'b00, da_q} + {2'b00, db_q};
	assign dtwice   = {1'b0, dep_rdata, 1'b0};

	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (mode_q)
					MODE_LOAD:  state_d = ST_DONE;
					MODE_BUILD: state_d = (active == 11'd0) ? ST_DONE : ST_B0_RD;
					MODE_LCA:   state_d = (a_ok && b_ok) ? ST_LCA_DA : ST_DONE;
					MODE_KTH:   state_d = a_ok ? ST_CLIMB : ST_DONE;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_LCA_DA:     state_d = ST_LCA_DB;
			ST_LCA_DB:     state_d = ST_CLIMB;
			ST_CLIMB: begin
				if (p_q == NODE_NONE) state_d = ST_CLIMB_END;
				else if (take) state_d = ST_CLIMB_WAIT;
				else if (lvl_q == '0) state_d = ST_CLIMB_END;
			end
			ST_CLIMB_WAIT: state_d = ST_CLIMB;
			ST_CLIMB_END: begin
				if (mode_q == MODE_KTH || p_q == NODE_NONE) state_d = ST_DONE;
				else if (p_q == q_q) state_d = ST_LCA_DIST;
				else state_d = ST_LCA_JP;
			end
			ST_LCA_JP:     state_d = ST_LCA_JQ;
			ST_LCA_JQ:     state_d = ST_LCA_CMP;
			ST_LCA_CMP:    state_d = (lvl_q == '0) ? ST_LCA_PAR : ST_LCA_JP;
			ST_LCA_PAR:    state_d = ST_LCA_PARW;
			ST_LCA_PARW:   state_d = (par_norm == NODE_NONE) ? ST_DONE : ST_LCA_DIST;
			ST_LCA_DIST:   state_d = ST_LCA_DISTW;
			ST_LCA_DISTW:  state_d = ST_DONE;
			ST_B0_RD:      state_d = ST_B0_WR;
			ST_B0_WR:      state_d = last_v ? ST_BJ_RD : ST_B0_RD;
			ST_BJ_RD:      state_d = ST_BJ_MID;
			ST_BJ_MID: begin
				if (jmp_norm != NODE_NONE) state_d = ST_BJ_WR;
				else if (last_v && lvl_q == LVL_TOP) state_d = ST_DONE;
				else state_d = ST_BJ_RD;
			end
			ST_BJ_WR:      state_d = (last_v && lvl_q == LVL_TOP) ? ST_DONE : ST_BJ_RD;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// ---------------- table ports ----------------
	always_comb begin
		tbl_wr     = '0;
		node_waddr = nidx(a_node);
		par_raddr  = nidx(p_q);
		dep_raddr  = nidx(a_node);
		jmp_raddr  = jaddr(p_q, lvl_q);
		jmp_waddr  = jaddr(v_node, lvl_q);
		jmp_wdata  = jmp_norm;
		case (state_q)
			ST_DISPATCH: begin
				if (mode_q == MODE_LOAD && load_ok) begin
					tbl_wr.par_we = 1'b1;
					tbl_wr.dep_we = 1'b1;
				end
			end
			ST_LCA_DA:   dep_raddr = nidx(b_q);
			ST_LCA_JQ:   jmp_raddr = jaddr(q_q, lvl_q);
			ST_LCA_DIST: dep_raddr = nidx(ans_q);
			ST_B0_RD:    par_raddr = nidx(v_node);
			ST_B0_WR: begin
				tbl_wr.jmp_we = 1'b1;
				jmp_wdata     = par_norm;
			end
			ST_BJ_RD:    jmp_raddr = jaddr(v_node, LW'(lvl_q - 1'b1));
			ST_BJ_MID: begin
				// a parent of none: the entry is none, no second read
				jmp_raddr     = jaddr(jmp_norm, LW'(lvl_q - 1'b1));
				tbl_wr.jmp_we = (jmp_norm == NODE_NONE);
			end
			ST_BJ_WR:    tbl_wr.jmp_we = 1'b1;
			default: ;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			node_count_q   <= 11'd1;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) node_count_q <= cfg_data;
			if (state_q == ST_DONE && out_free) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q   <= item.mode;
				a_q      <= item.node_a;
				b_q      <= item.node_b;
				dep_q    <= item.depth_in;
				k_q      <= item.steps;
				p_q      <= a_node;
				ans_q    <= NODE_NONE;
				dist_q   <= '0;
				status_q <= 1'b0;
			end
			ST_DISPATCH: begin
				v_q   <= 11'd1;
				lvl_q <= (mode_q == MODE_BUILD) ? '0 : LVL_TOP;
				p_q   <= a_node;
				case (mode_q)
					MODE_LOAD: status_q <= !load_ok;
					MODE_LCA:  status_q <= !(a_ok && b_ok);
					MODE_KTH:  status_q <= !a_ok;
					default:   status_q <= 1'b0;
				endcase
			end
			ST_LCA_DA: da_q <= dep_rdata;
			ST_LCA_DB: begin
				db_q  <= dep_rdata;
				lvl_q <= LVL_TOP;
				// deeper node climbs to the depth of the other
				if (da_q < dep_rdata) begin
					p_q <= b_q;
					q_q <= a_node;
					k_q <= dep_rdata - da_q;
				end else begin
					p_q <= a_node;
					q_q <= b_q;
					k_q <= da_q - dep_rdata;
				end
			end
			ST_CLIMB: begin
				if (p_q != NODE_NONE) begin
					if (take) k_q <= k_q - span;
					else if (lvl_q != '0) lvl_q <= lvl_q - 1'b1;
				end
			end
			ST_CLIMB_WAIT: p_q <= jmp_norm;
			ST_CLIMB_END: begin
				lvl_q <= LVL_TOP;
				if (mode_q == MODE_KTH || (p_q != NODE_NONE && p_q == q_q)) ans_q <= p_q;
			end
			ST_LCA_JQ: jp_q <= jmp_norm;
			ST_LCA_CMP: begin
				if (jp_q != jq && jp_q != NODE_NONE) begin
					p_q <= jp_q;
					q_q <= jq;
				end
				if (lvl_q != '0) lvl_q <= lvl_q - 1'b1;
			end
			ST_LCA_PARW: ans_q <= par_norm;
			ST_LCA_DISTW: dist_q <= (dsum >= dtwice) ? 11'(dsum - dtwice) : 11'd0;
			ST_B0_WR: begin
				if (last_v) begin
					v_q   <= 11'd1;
					lvl_q <= LW'(1);
				end else begin
					v_q <= v_q + 11'd1;
				end
			end
			ST_BJ_MID, ST_BJ_WR: begin
				if (state_q == ST_BJ_WR || jmp_norm == NODE_NONE) begin
					if (last_v) begin
						v_q   <= 11'd1;
						lvl_q <= LW'(lvl_q + 1'b1);
					end else begin
						v_q <= v_q + 11'd1;
					end
				end
			end
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_q.answer_node <= ans_q;
			result_q.distance    <= dist_q;
			result_q.status      <= status_q;
		end
	end

	// ---------------- assertions ----------------
	`BLAE_ASSERT_NEXT(a_done_hands_off, clk, arst_n,
		state_q == ST_DONE && out_free, result_valid_q && state_q == ST_IDLE)
	`BLAE_ASSERT_NOW(a_node_wr_only_load, clk, arst_n,
		tbl_wr.par_we || tbl_wr.dep_we, state_q == ST_DISPATCH && mode_q == MODE_LOAD)
	`BLAE_ASSERT_NOW(a_jump_wr_in_range, clk, arst_n,
		tbl_wr.jmp_we, v_q != 11'd0 && v_q <= active && lvl_q <= LVL_TOP)
	`BLAE_ASSERT_NOW(a_flagged_is_empty, clk, arst_n,
		result_valid && result.status,
		result.answer_node == NODE_NONE && result.distance == 11'd0)

endmodule

`default_nettype wire

// ----- test/ancestor_checker.sv -----
`timescale 1ns / 1ps

// Watches all three channels, keeps its own copy of the tree tables and
// the node count, and matches each result transfer against the oldest
// expected answer.
module ancestor_checker import blae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output int          mismatches,
	output int          answers_open
);

	localparam int NODES  = 1024;
	localparam int LEVELS = 11;

	typedef struct packed {
		item_t   cause;
		result_t want;
	} due_t;

	logic [10:0] node_limit;
	node_t       parent_of [1:NODES];
	logic [9:0]  level_of [1:NODES];
	node_t       hop [1:NODES][0:LEVELS-1];
	due_t        answers_due [$];
	int          miss_total = 0;

	function automatic int live_count();
		return (node_limit > 11'd1024) ? NODES : int'(node_limit);
	endfunction

	function automatic node_t in_tree(node_t v);
		int vi;
		vi = v;
		return (vi >= 1 && vi <= live_count()) ? v : NODE_NONE;
	endfunction

	function automatic node_t jump_from(node_t v, int lvl);
		if (in_tree(v) == NODE_NONE)
			return NODE_NONE;
		return in_tree(hop[v][lvl]);
	endfunction

	// walk k levels up, top jump first; none once past the root
	function automatic node_t climb_up(node_t v, int unsigned k);
		int unsigned span;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			span = 1 << i;
			while (k >= span && v != NODE_NONE) begin
				k -= span;
				v = jump_from(v, i);
			end
		end
		return v;
	endfunction

	function automatic node_t meet_point(node_t p, node_t q);
		node_t t, jp, jq;
		if (level_of[p] < level_of[q]) begin
			t = p;
			p = q;
			q = t;
		end
		p = climb_up(p, level_of[p] - level_of[q]);
		if (p == NODE_NONE)
			return NODE_NONE;
		if (p == q)
			return p;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			jp = jump_from(p, i);
			jq = jump_from(q, i);
			if (jp != jq && jp != NODE_NONE) begin
				p = jp;
				q = jq;
			end
		end
		return in_tree(parent_of[p]);
	endfunction

	function automatic void fill_jumps();
		node_t mid;
		int n;
		n = live_count();
		for (int v = 1; v <= n; v++)
			hop[v][0] = in_tree(parent_of[v]);
		for (int j = 1; j < LEVELS; j++)
			for (int v = 1; v <= n; v++) begin
				mid = jump_from(node_t'(v), j - 1);
				hop[v][j] = (mid == NODE_NONE) ? NODE_NONE : jump_from(mid, j - 1);
			end
	endfunction

	// applies the item to the tables and returns its answer
	function automatic result_t predict_answer(item_t it);
		result_t r;
		node_t a, b;
		int d;
		a = node_t'({1'b0, it.node_a});
		b = it.node_b;
		r.answer_node = NODE_NONE;
		r.distance = '0;
		r.status = 1'b0;
		case (it.mode)
		MODE_LOAD: begin
			if (in_tree(a) == NODE_NONE || (b != NODE_NONE && in_tree(b) == NODE_NONE)) begin
				r.status = 1'b1;
			end else begin
				parent_of[a] = b;
				level_of[a] = it.depth_in;
			end
		end
		MODE_BUILD: begin
			fill_jumps();
		end
		MODE_LCA: begin
			if (in_tree(a) == NODE_NONE || in_tree(b) == NODE_NONE) begin
				r.status = 1'b1;
			end else begin
				r.answer_node = meet_point(a, b);
				if (r.answer_node != NODE_NONE) begin
					d = int'(level_of[a]) + int'(level_of[b])
						- 2 * int'(level_of[r.answer_node]);
					r.distance = (d < 0) ? '0 : d[10:0];
				end
			end
		end
		default: begin
			if (in_tree(a) == NODE_NONE)
				r.status = 1'b1;
			else
				r.answer_node = climb_up(a, it.steps);
		end
		endcase
		return r;
	endfunction

	task automatic note_miss(string what, int got, int want, item_t cause);
		miss_total++;
		if (miss_total <= 100)
			$display("%0t mismatch on %s: got %0d, expected %0d (mode %0d a %0d b %0d steps %0d)",
				$time, what, got, want, cause.mode, cause.node_a, cause.node_b, cause.steps);
	endtask

	always @(posedge clk or negedge arst_n) begin
		due_t head, fresh;
		if (!arst_n) begin
			node_limit = 11'd1;
			answers_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				node_limit = cfg_data;
			// retire before queueing: a result never belongs to the item taken at the same edge
			if (result_valid && !result_stall) begin
				if (answers_due.size() == 0) begin
					note_miss("unexpected result", result.answer_node, 0, '0);
				end else begin
					head = answers_due.pop_front();
					if (result.answer_node !== head.want.answer_node)
						note_miss("answer_node", result.answer_node, head.want.answer_node,
							head.cause);
					if (result.distance !== head.want.distance)
						note_miss("distance", result.distance, head.want.distance, head.cause);
					if (result.status !== head.want.status)
						note_miss("status", result.status, head.want.status, head.cause);
				end
			end
			if (item_valid && !item_stall) begin
				fresh.cause = item;
				fresh.want = predict_answer(item);
				answers_due.push_back(fresh);
			end
		end
		mismatches <= miss_total;
		answers_open <= answers_due.size();
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the ancestor engine bench: makes trees and queries, drives both
// stream sides with random gaps and stalls, and gives the verdict. All
// answer checking lives in ancestor_checker.
module tb_top;
	import blae_pkg::*;

	localparam int ITEM_TARGET = 1850;
	// longest quiet stretch: a build over 1024 nodes
	localparam int WATCH_LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;

	int mismatches;
	int answers_open;

	// calm: no gaps and no stalls for the current phase
	logic calm = 1'b0;
	int   sent = 0;
	int   per_mode [4] = '{0, 0, 0, 0};
	int   phases = 0;
	int   biggest = 1;
	int   cfg_writes = 0;
	int   idle_cycles = 0;
	// span: nodes in use; ready_top: nodes 1..ready_top loaded and built at some point
	int   span = 1;
	int   ready_top = 0;
	int   tree_up [1:1024];
	int   tree_depth [1:1024];
	int   load_seq [1:1024];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	binary_lifting_ancestor_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	ancestor_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.answers_open(answers_open)
	);

	// Watchdog: any transfer on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d answers outstanding",
				WATCH_LIMIT, answers_open);
			$display("binary_lifting_ancestor_engine regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: after every transfer draw a random stall for the next one.
	// The stall runs whether or not a result is waiting.
	initial begin
		int hold;
		logic taken;
		hold = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			taken = result_valid && !result_stall;
			@(negedge clk);
			if (taken)
				hold = calm ? 0 : $urandom_range(0, 8);
			if (hold > 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	function automatic item_t make_item(logic [1:0] mode, int a, int b, int dep, int steps);
		item_t it;
		it.mode = mode;
		it.node_a = a[10:0];
		it.node_b = b[11:0];
		it.depth_in = dep[9:0];
		it.steps = steps[9:0];
		return it;
	endfunction

	// node number outside 1..span, anywhere in the 11-bit field
	function automatic int odd_node();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(span + 1, 2047);
	endfunction

	// parent field that is neither -1 nor a node in use
	function automatic int odd_link();
		case ($urandom_range(0, 2))
		0: begin
			return 0;
		end
		1: begin
			return -int'($urandom_range(2, 2048));
		end
		default: begin
			return $urandom_range(span + 1, 2047);
		end
		endcase
	endfunction

	// flagged items: they never touch the tables
	function automatic item_t junk_item();
		int a;
		a = $urandom_range(1, span);
		case ($urandom_range(0, 3))
		0: begin
			return make_item(MODE_LOAD, odd_node(), $urandom_range(0, 4095),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
		end
		1: begin
			return make_item(MODE_LOAD, a, odd_link(), $urandom_range(0, 1023),
				$urandom_range(0, 1023));
		end
		2: begin
			if ($urandom_range(0, 1))
				return make_item(MODE_LCA, odd_node(), a, $urandom_range(0, 1023),
					$urandom_range(0, 1023));
			return make_item(MODE_LCA, a, $urandom_range(0, 1) ? -1 : odd_link(),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
		end
		default: begin
			return make_item(MODE_KTH, odd_node(), $urandom_range(0, 4095),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
		end
		endcase
	endfunction

	// mostly well-formed queries; some reloads and rebuilds on top of the built table
	function automatic item_t query_item();
		int a, b, r, lim;
		a = $urandom_range(1, span);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			if (r < 6)
				b = a;
			else if (r < 12 && tree_up[a] >= 1 && tree_up[a] <= span)
				b = tree_up[a];
			else
				b = $urandom_range(1, span);
			return make_item(MODE_LCA, a, b, $urandom_range(0, 1023), $urandom_range(0, 1023));
		end
		if (r < 75) begin
			lim = tree_depth[a] + 2;
			if (lim > 1023)
				lim = 1023;
			return make_item(MODE_KTH, a, $urandom_range(0, 4095), $urandom_range(0, 1023),
				$urandom_range(0, 1) ? $urandom_range(0, lim) : $urandom_range(0, 1023));
		end
		if (r < 88)
			return junk_item();
		if (r < 96) begin
			b = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(1, span);
			tree_up[a] = b;
			tree_depth[a] = (b < 1) ? 0 : tree_depth[b] + 1;
			if (tree_depth[a] > 1023 || $urandom_range(0, 5) == 0)
				tree_depth[a] = $urandom_range(0, 1023);
			return make_item(MODE_LOAD, a, b, tree_depth[a], $urandom_range(0, 1023));
		end
		return make_item(MODE_BUILD, $urandom_range(0, 2047), $urandom_range(0, 4095),
			$urandom_range(0, 1023), $urandom_range(0, 1023));
	endfunction

	// one item transfer; valid stays high into the next item when no gap is drawn
	task automatic send_item(item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(item_valid && !item_stall));
		sent++;
		per_mode[it.mode]++;
	endtask

	// hold off until every expected answer has come back
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (answers_open != 0)
			@(posedge clk);
	endtask

	task automatic set_count(int v);
		@(negedge clk);
		cfg_data <= v[10:0];
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		span = (v > 1024) ? 1024 : v;
		if (span > biggest)
			biggest = span;
		cfg_writes++;
	endtask

	// node 1 is a root; deep trees mostly chain onto the previous node
	task automatic grow_tree(int n, logic deep);
		int pick;
		for (int i = 1; i <= n; i++) begin
			pick = $urandom_range(0, 15);
			if (i == 1 || (!deep && pick == 0)) begin
				tree_up[i] = -1;
				tree_depth[i] = 0;
			end else begin
				tree_up[i] = (deep && pick < 13) ? i - 1 : $urandom_range(1, i - 1);
				tree_depth[i] = tree_depth[tree_up[i]] + 1;
			end
			// now and then a depth that does not fit the tree
			if ($urandom_range(0, 47) == 0)
				tree_depth[i] = $urandom_range(0, 1023);
			if (tree_depth[i] > 1023)
				tree_depth[i] = 1023;
		end
	endtask

	// loads every node once in shuffled order, with flagged items sprinkled in
	task automatic load_tree(int n);
		int j, k;
		for (int i = 1; i <= n; i++)
			load_seq[i] = i;
		for (int i = n; i >= 2; i--) begin
			j = $urandom_range(1, i);
			k = load_seq[i];
			load_seq[i] = load_seq[j];
			load_seq[j] = k;
		end
		for (int i = 1; i <= n; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_item(junk_item());
			k = load_seq[i];
			send_item(make_item(MODE_LOAD, k, tree_up[k], tree_depth[k], $urandom_range(0, 1023)));
		end
	endtask

	initial begin
		int want_count, queries;
		logic deep, rebuild, shrink;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, node_count still 1: flagged numbers on every mode but build, the
		// single-node tree, and a climb past its root.
		send_item(make_item(MODE_LCA, 0, 1, 0, 0));
		send_item(make_item(MODE_KTH, 2047, -1, 1023, 1023));
		send_item(make_item(MODE_LOAD, 2, -1, 0, 0));
		send_item(make_item(MODE_LOAD, 1, 2, 0, 0));
		send_item(make_item(MODE_LOAD, 1, -2048, 0, 0));
		send_item(make_item(MODE_LOAD, 1, -1, 0, 0));
		send_item(make_item(MODE_BUILD, 0, 0, 0, 0));
		send_item(make_item(MODE_KTH, 1, 0, 0, 1));

		// Small forest: roots 1 and 6. Node 5 claims depth 1023 so climbs to
		// equal depth run off the top; root 6 sits at depth 9 so its children
		// give a negative distance that must clamp.
		settle();
		set_count(8);
		send_item(make_item(MODE_LOAD, 1, -1, 0, 0));
		send_item(make_item(MODE_LOAD, 2, 1, 1, 0));
		send_item(make_item(MODE_LOAD, 3, 1, 1, 0));
		send_item(make_item(MODE_LOAD, 4, 2, 2, 0));
		send_item(make_item(MODE_LOAD, 5, 4, 1023, 0));
		send_item(make_item(MODE_LOAD, 6, -1, 9, 0));
		send_item(make_item(MODE_LOAD, 7, 6, 1, 0));
		send_item(make_item(MODE_LOAD, 8, 6, 1, 0));
		send_item(make_item(MODE_BUILD, 0, 0, 0, 0));
		send_item(make_item(MODE_LCA, 4, 3, 0, 0));
		send_item(make_item(MODE_LCA, 7, 8, 0, 0));
		send_item(make_item(MODE_LCA, 5, 1, 0, 0));
		send_item(make_item(MODE_LCA, 3, 7, 0, 0));
		send_item(make_item(MODE_KTH, 5, 0, 0, 2));
		send_item(make_item(MODE_KTH, 5, 0, 0, 1023));
		send_item(make_item(MODE_LCA, 1, -1, 0, 0));
		ready_top = 8;

		// Random phases. Each one drains, writes node_count, then either loads
		// and builds a fresh tree or shrinks onto nodes loaded earlier, so that
		// stored links beyond the new count read as none.
		while (sent < ITEM_TARGET) begin
			phases++;
			calm = ($urandom_range(0, 3) == 0);
			deep = $urandom_range(0, 1);
			rebuild = 1'b1;
			shrink = 1'b0;
			queries = $urandom_range(12, 40);
			if (phases == 1) begin
				// register at its top value: acts as the full 1024 nodes
				want_count = 2047;
				deep = 1'b1;
				queries = 120;
			end else if (phases == 2) begin
				shrink = 1'b1;
				rebuild = 1'b0;
				want_count = $urandom_range(300, 1000);
			end else if (phases == 3) begin
				want_count = 1;
			end else if ($urandom_range(0, 5) == 0) begin
				shrink = 1'b1;
				rebuild = $urandom_range(0, 1);
				want_count = $urandom_range(1, ready_top);
			end else if ($urandom_range(0, 7) == 0) begin
				want_count = $urandom_range(41, 160);
			end else begin
				want_count = $urandom_range(2, 40);
			end

			settle();
			set_count(want_count);
			if (!shrink) begin
				grow_tree(span, deep);
				load_tree(span);
			end
			if (rebuild)
				send_item(make_item(MODE_BUILD, $urandom_range(0, 2047), $urandom_range(0, 4095),
					$urandom_range(0, 1023), $urandom_range(0, 1023)));
			if (!shrink && span > ready_top)
				ready_top = span;
			repeat (queries)
				send_item(query_item());
		end

		settle();
		repeat (40) @(posedge clk);

		$display("covered %0d items: %0d loads, %0d builds, %0d common ancestor, %0d k-th ancestor",
			sent, per_mode[MODE_LOAD], per_mode[MODE_BUILD], per_mode[MODE_LCA], per_mode[MODE_KTH]);
		$display("%0d tree phases, %0d node_count writes, largest tree %0d nodes, %0d mismatches",
			phases, cfg_writes, biggest, mismatches);
		if (mismatches == 0 && answers_open == 0)
			$display("binary_lifting_ancestor_engine regression: pass");
		else
			$display("binary_lifting_ancestor_engine regression: fail");
		$finish;
	end

endmodule
